@@ src/lpwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpwd_pkg
// Shared types and constants of the length-prefixed word deframer: result
// kinds, reply codes, prefix masks and the three reply patterns.
// ----------------------------------------------------------------------------
package lpwd_pkg;

  localparam int unsigned ACC_W = 29;
  localparam int unsigned POS_W = 3;
  localparam int unsigned PAT_DEPTH = 6;

  typedef logic [7:0] byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [PAT_DEPTH-1:0][7:0] pat_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_DONE  = 2'd1,
    REPLY_TRAP  = 2'd2,
    REPLY_FATAL = 2'd3
  } reply_e;

  localparam byte_t PFX4_MASK = 8'hE0;
  localparam byte_t PFX3_MASK = 8'hC0;
  localparam byte_t PFX2_MASK = 8'h80;
  localparam byte_t PFX4_DATA = 8'h1F;
  localparam byte_t PFX3_DATA = 8'h3F;
  localparam byte_t PFX2_DATA = 8'h7F;

  localparam pat_t PAT_DONE  = {8'h00, "e", "n", "o", "d", "!"};
  localparam pat_t PAT_TRAP  = {8'h00, "p", "a", "r", "t", "!"};
  localparam pat_t PAT_FATAL = {"l", "a", "t", "a", "f", "!"};
  localparam pos_t LEN_DONE  = 3'd5;
  localparam pos_t LEN_TRAP  = 3'd5;
  localparam pos_t LEN_FATAL = 3'd6;

  // Hit flags of one word: done, trap, fatal.
  typedef struct packed {
    logic fatal;
    logic trap;
    logic done;
  } hits_t;

  // Control from the framing logic to the pattern scanner.
  typedef struct packed {
    logic step;
    logic clear;
  } scan_ctrl_t;

endpackage

@@ src/lpwd_if.sv @@
// ----------------------------------------------------------------------------
// lpwd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface lpwd_in_if;
  logic             valid;
  logic             ready;
  lpwd_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpwd_out_if;
  logic             valid;
  logic             ready;
  logic             out_kind;
  lpwd_pkg::byte_t  payload_byte;
  logic             word_first;
  logic             word_last;
  logic [1:0]       reply_type;

  modport source (
    output valid, output out_kind, output payload_byte, output word_first,
    output word_last, output reply_type, input ready
  );
  modport sink (
    input valid, input out_kind, input payload_byte, input word_first,
    input word_last, input reply_type, output ready
  );
endinterface

@@ src/length_prefixed_word_deframer_core.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_word_deframer_core
// Decodes 1 to 4 byte length prefixes, passes word payload bytes through
// with first and last marks, and reports the sentence reply type at the
// empty word that ends each sentence.
// ----------------------------------------------------------------------------
// The block takes one received byte in every clock cycle unless its output
// register holds a stalled beat, with no bubbles between words or sentences.
// Each payload byte and each empty word yields one result beat in the cycle
// after the byte is taken; prefix bytes yield no beat. The result sits in a
// single output register, and a new byte is taken whenever that register is
// empty or its beat is taken in the same cycle, so source and sink set the rate.
module length_prefixed_word_deframer_core #(
  parameter int unsigned LENGTH_BITS = 29
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpwd_in_if.sink     rx_i,
  lpwd_out_if.source  tx_o
);
  import lpwd_pkg::*;

  localparam logic [ACC_W-1:0] LenMax = ACC_W'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [1:0]             prefix_left_q, prefix_left_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [LENGTH_BITS-1:0] payload_left_q, payload_left_d;
  logic                   first_q, first_d;
  reply_e                 reply_q, reply_d;

  logic                   out_valid_q, out_valid_d;
  kind_e                  out_kind_q, out_kind_d;
  byte_t                  out_byte_q, out_byte_d;
  logic                   out_first_q, out_first_d;
  logic                   out_last_q, out_last_d;
  reply_e                 out_reply_q, out_reply_d;

  logic                   accept;
  logic                   emit;
  logic                   fin;
  logic [ACC_W-1:0]       fin_len;
  logic [ACC_W-1:0]       acc_shift;
  logic [LENGTH_BITS-1:0] sat_len;
  byte_t                  b;
  scan_ctrl_t             scan_ctrl;
  hits_t                  hits;

  assign b         = rx_i.rx_byte;
  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign accept    = rx_i.valid && rx_i.ready;
  assign acc_shift = {acc_q[ACC_W-9:0], b};
  assign sat_len   = (fin_len > LenMax) ? LenMax[LENGTH_BITS-1:0] : fin_len[LENGTH_BITS-1:0];

  lpwd_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .byte_i (b),
    .hits_o (hits)
  );

  always_comb begin
    prefix_left_d  = prefix_left_q;
    acc_d          = acc_q;
    payload_left_d = payload_left_q;
    first_d        = first_q;
    reply_d        = reply_q;
    scan_ctrl      = '0;
    emit           = 1'b0;
    fin            = 1'b0;
    fin_len        = '0;
    out_kind_d     = KIND_PAYLOAD;
    out_byte_d     = '0;
    out_first_d    = 1'b0;
    out_last_d     = 1'b0;
    out_reply_d    = REPLY_NONE;

    if (accept) begin
      if (prefix_left_q != 2'd0) begin
        acc_d         = acc_shift;
        prefix_left_d = prefix_left_q - 2'd1;
        if (prefix_left_q == 2'd1) begin
          fin     = 1'b1;
          fin_len = acc_shift;
        end
      end else if (payload_left_q != '0) begin
        emit           = 1'b1;
        scan_ctrl.step = 1'b1;
        out_byte_d     = b;
        out_first_d    = first_q;
        out_last_d     = (payload_left_q == LENGTH_BITS'(1));
        first_d        = 1'b0;
        payload_left_d = payload_left_q - LENGTH_BITS'(1);
        if (payload_left_q == LENGTH_BITS'(1)) begin
          scan_ctrl.clear = 1'b1;
          first_d         = 1'b1;
          if (hits.done) begin
            reply_d = REPLY_DONE;
          end else if (hits.trap) begin
            reply_d = REPLY_TRAP;
          end else if (hits.fatal) begin
            reply_d = REPLY_FATAL;
          end
        end
      end else if ((b & PFX4_MASK) == PFX4_MASK) begin
        acc_d         = ACC_W'(b & PFX4_DATA);
        prefix_left_d = 2'd3;
      end else if ((b & PFX3_MASK) == PFX3_MASK) begin
        acc_d         = ACC_W'(b & PFX3_DATA);
        prefix_left_d = 2'd2;
      end else if ((b & PFX2_MASK) == PFX2_MASK) begin
        acc_d         = ACC_W'(b & PFX2_DATA);
        prefix_left_d = 2'd1;
      end else begin
        fin     = 1'b1;
        fin_len = ACC_W'(b);
      end

      if (fin) begin
        acc_d           = '0;
        prefix_left_d   = 2'd0;
        scan_ctrl.clear = 1'b1;
        first_d         = 1'b1;
        if (fin_len == '0) begin
          emit        = 1'b1;
          out_kind_d  = KIND_END;
          out_reply_d = reply_q;
          reply_d     = REPLY_NONE;
        end else begin
          payload_left_d = sat_len;
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_left_q  <= '0;
      acc_q          <= '0;
      payload_left_q <= '0;
      first_q        <= 1'b1;
      reply_q        <= REPLY_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      prefix_left_q  <= prefix_left_d;
      acc_q          <= acc_d;
      payload_left_q <= payload_left_d;
      first_q        <= first_d;
      reply_q        <= reply_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= out_kind_d;
      out_byte_q  <= out_byte_d;
      out_first_q <= out_first_d;
      out_last_q  <= out_last_d;
      out_reply_q <= out_reply_d;
    end
  end

  assign tx_o.valid        = out_valid_q;
  assign tx_o.out_kind     = out_kind_q;
  assign tx_o.payload_byte = out_byte_q;
  assign tx_o.word_first   = out_first_q;
  assign tx_o.word_last    = out_last_q;
  assign tx_o.reply_type   = out_reply_q;

  // A length prefix and a word payload are never in progress together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_left_q != 2'd0 |-> payload_left_q == '0)
    else $error("prefix and payload counters both active");

  // The last payload byte of a word arms the first mark for the next word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && prefix_left_q == 2'd0 && payload_left_q == LENGTH_BITS'(1) |=> first_q)
    else $error("first mark not rearmed after word end");

  // An end-of-sentence beat clears the sentence reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_kind_d == KIND_END |=> reply_q == REPLY_NONE)
    else $error("sentence reply not cleared at sentence end");

  // A stalled result is never overwritten by a new beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !tx_o.ready |-> !accept)
    else $error("byte accepted while result stalled");

endmodule

@@ src/lpwd_scan.sv @@
// ----------------------------------------------------------------------------
// lpwd_scan
// Substring scanner for the reply patterns. Tracks the matched length of
// each pattern and the hits seen so far in the current word.
// ----------------------------------------------------------------------------
module lpwd_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpwd_pkg::scan_ctrl_t ctrl_i,
  input  lpwd_pkg::byte_t      byte_i,
  output lpwd_pkg::hits_t      hits_o
);
  import lpwd_pkg::*;

  typedef struct packed {
    pos_t pos;
    logic hit;
  } step_t;

  function automatic step_t match_step(pos_t pos, byte_t b, pat_t pat, pos_t len);
    step_t r;
    pos_t  p;
    p = (pos >= len) ? '0 : pos;
    r.hit = 1'b0;
    if (b == pat[p]) begin
      if (p + 3'd1 == len) begin
        r.hit = 1'b1;
        r.pos = '0;
      end else begin
        r.pos = p + 3'd1;
      end
    end else begin
      r.pos = (b == pat[0]) ? 3'd1 : 3'd0;
    end
    return r;
  endfunction

  pos_t  done_pos_q, trap_pos_q, fatal_pos_q;
  hits_t hits_q, hits_d;
  step_t done_s, trap_s, fatal_s;

  always_comb begin
    done_s  = match_step(done_pos_q, byte_i, PAT_DONE, LEN_DONE);
    trap_s  = match_step(trap_pos_q, byte_i, PAT_TRAP, LEN_TRAP);
    fatal_s = match_step(fatal_pos_q, byte_i, PAT_FATAL, LEN_FATAL);
    hits_d  = hits_q;
    if (ctrl_i.step) begin
      hits_d.done  = hits_q.done | done_s.hit;
      hits_d.trap  = hits_q.trap | trap_s.hit;
      hits_d.fatal = hits_q.fatal | fatal_s.hit;
    end
  end

  assign hits_o = hits_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_pos_q  <= '0;
      trap_pos_q  <= '0;
      fatal_pos_q <= '0;
      hits_q      <= '0;
    end else if (ctrl_i.clear) begin
      done_pos_q  <= '0;
      trap_pos_q  <= '0;
      fatal_pos_q <= '0;
      hits_q      <= '0;
    end else if (ctrl_i.step) begin
      done_pos_q  <= done_s.pos;
      trap_pos_q  <= trap_s.pos;
      fatal_pos_q <= fatal_s.pos;
      hits_q      <= hits_d;
    end
  end

endmodule

@@ tb/length_prefixed_word_deframer_core_tb.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_word_deframer_core_tb
// Self-checking bench for the word deframer. A short table of bytes
// covers the prefix sizes, the done reply and empty words. Random
// sentences follow, built from words whose payloads mix whole and broken
// reply patterns with plain bytes. Every result beat is checked against the
// table's fixed beat or a behavioral model of the framing and pattern logic.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module length_prefixed_word_deframer_core_tb;
  import lpwd_pkg::*;

  typedef struct packed {
    kind_e  kind;
    byte_t  data;
    logic   first;
    logic   last;
    reply_e reply;
  } beat_t;

  typedef struct packed {
    byte_t rx;
    logic  fixed;
    beat_t res;
  } dir_row_t;

  localparam int unsigned STREAM_BYTES = 750;
  localparam int unsigned TAIL_BYTES = 20;

  localparam beat_t NO_BEAT = '0;
  localparam beat_t END_NONE = '{kind: KIND_END, data: 8'h00, first: 1'b0, last: 1'b0,
                                 reply: REPLY_NONE};
  localparam beat_t END_DONE = '{kind: KIND_END, data: 8'h00, first: 1'b0, last: 1'b0,
                                 reply: REPLY_DONE};
  localparam beat_t PAY_ZERO = '{kind: KIND_PAYLOAD, data: 8'h00, first: 1'b1, last: 1'b1,
                                 reply: REPLY_NONE};

  localparam dir_row_t FRAMING_CASES [24] = '{
    '{8'h00, 1'b1, END_NONE},
    '{8'h05, 1'b0, NO_BEAT},
    '{8'h21, 1'b0, NO_BEAT},
    '{8'h64, 1'b0, NO_BEAT},
    '{8'h6F, 1'b0, NO_BEAT},
    '{8'h6E, 1'b0, NO_BEAT},
    '{8'h65, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, END_DONE},
    '{8'h80, 1'b0, NO_BEAT},
    '{8'h01, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, PAY_ZERO},
    '{8'h00, 1'b1, END_NONE},
    '{8'hE0, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, END_NONE},
    '{8'hC0, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, END_NONE},
    '{8'h80, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, END_NONE},
    '{8'h01, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, END_NONE}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpwd_in_if  rx_if ();
  lpwd_out_if tx_if ();

  length_prefixed_word_deframer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  always #1 clk_i = ~clk_i;

  // Model state of the deframer.
  logic [1:0]  pfx_left;
  logic [28:0] len_acc;
  logic [28:0] pay_left;
  bit          word_open;
  pos_t        m_done;
  pos_t        m_trap;
  pos_t        m_fatal;
  hits_t       word_hits;
  reply_e      sent_reply;

  beat_t       want_q[$];
  byte_t       stream_q[$];
  int unsigned err_cnt = 0;
  int unsigned n_bytes = 0;
  int unsigned n_payload = 0;
  int unsigned n_end = 0;
  int unsigned reply_seen[4] = '{0, 0, 0, 0};
  int unsigned src_calm = 0;
  int unsigned sink_calm = 0;
  int unsigned sink_hold = 0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic pos_t scan_step(pos_t pos, byte_t b, pat_t pat, pos_t plen,
                                     output bit hit);
    pos_t p;
    p = (pos >= plen) ? pos_t'(0) : pos;
    hit = 1'b0;
    if (b == pat[p]) begin
      p = p + 1'b1;
      if (p == plen) begin
        hit = 1'b1;
        p = '0;
      end
    end else begin
      p = (b == pat[0]) ? pos_t'(1) : pos_t'(0);
    end
    return p;
  endfunction

  task automatic open_word();
    word_open = 1'b1;
    m_done = '0;
    m_trap = '0;
    m_fatal = '0;
    word_hits = '0;
  endtask

  task automatic close_length(input logic [28:0] l, output bit emits, output beat_t beat);
    len_acc = '0;
    pfx_left = '0;
    emits = 1'b0;
    beat = NO_BEAT;
    if (l == 0) begin
      emits = 1'b1;
      beat = '{kind: KIND_END, data: 8'h00, first: 1'b0, last: 1'b0, reply: sent_reply};
      sent_reply = REPLY_NONE;
    end else begin
      pay_left = l;
    end
    open_word();
  endtask

  task automatic deframe_byte(input byte_t b, output bit emits, output beat_t beat);
    bit hd;
    bit ht;
    bit hf;
    emits = 1'b0;
    beat = NO_BEAT;
    if (pfx_left != 0) begin
      len_acc = {len_acc[20:0], b};
      pfx_left = pfx_left - 1'b1;
      if (pfx_left == 0) close_length(len_acc, emits, beat);
    end else if (pay_left != 0) begin
      m_done = scan_step(m_done, b, PAT_DONE, LEN_DONE, hd);
      m_trap = scan_step(m_trap, b, PAT_TRAP, LEN_TRAP, ht);
      m_fatal = scan_step(m_fatal, b, PAT_FATAL, LEN_FATAL, hf);
      if (hd) word_hits.done = 1'b1;
      if (ht) word_hits.trap = 1'b1;
      if (hf) word_hits.fatal = 1'b1;
      emits = 1'b1;
      beat = '{kind: KIND_PAYLOAD, data: b, first: word_open, last: (pay_left == 1),
               reply: REPLY_NONE};
      word_open = 1'b0;
      pay_left = pay_left - 1'b1;
      if (beat.last) begin
        if (word_hits.done) sent_reply = REPLY_DONE;
        else if (word_hits.trap) sent_reply = REPLY_TRAP;
        else if (word_hits.fatal) sent_reply = REPLY_FATAL;
        open_word();
      end
    end else if ((b & PFX4_MASK) == PFX4_MASK) begin
      len_acc = 29'(b & PFX4_DATA);
      pfx_left = 2'd3;
    end else if ((b & PFX3_MASK) == PFX3_MASK) begin
      len_acc = 29'(b & PFX3_DATA);
      pfx_left = 2'd2;
    end else if ((b & PFX2_MASK) == PFX2_MASK) begin
      len_acc = 29'(b & PFX2_DATA);
      pfx_left = 2'd1;
    end else begin
      close_length(29'(b), emits, beat);
    end
  endtask

  // The encoding is the shortest one that fits, or at random a longer one.
  task automatic add_length(input logic [28:0] l);
    int unsigned sz;
    if (l < 29'd128) sz = 1;
    else if (l < 29'd32768) sz = 2;
    else if (l < 29'd4194304) sz = 3;
    else sz = 4;
    if ($urandom_range(0, 3) == 0) sz = $urandom_range(sz, 4);
    case (sz)
      1: begin
        stream_q.push_back(l[7:0]);
      end
      2: begin
        stream_q.push_back(PFX2_MASK | byte_t'(l[14:8]));
        stream_q.push_back(l[7:0]);
      end
      3: begin
        stream_q.push_back(PFX3_MASK | byte_t'(l[21:16]));
        stream_q.push_back(l[15:8]);
        stream_q.push_back(l[7:0]);
      end
      default: begin
        stream_q.push_back(PFX4_MASK | byte_t'(l[28:24]));
        stream_q.push_back(l[23:16]);
        stream_q.push_back(l[15:8]);
        stream_q.push_back(l[7:0]);
      end
    endcase
  endtask

  task automatic add_word(input bit noisy);
    int unsigned len;
    int unsigned sel;
    int unsigned cnt;
    byte_t       body[$];
    pat_t        p;
    pos_t        plen;
    sel = $urandom_range(0, 9);
    if (sel < 7) len = $urandom_range(1, 12);
    else if (sel < 9) len = $urandom_range(13, 40);
    else len = $urandom_range(100, 400);
    while (body.size() < len) begin
      sel = $urandom_range(0, 9);
      if (noisy || sel >= 7) begin
        body.push_back(byte_t'($urandom_range(0, 255)));
      end else if (sel == 5) begin
        body.push_back(PAT_DONE[0]);
      end else if (sel == 6) begin
        body.push_back(8'h00);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            p = PAT_DONE;
            plen = LEN_DONE;
          end
          1: begin
            p = PAT_TRAP;
            plen = LEN_TRAP;
          end
          default: begin
            p = PAT_FATAL;
            plen = LEN_FATAL;
          end
        endcase
        cnt = (sel < 3) ? plen : $urandom_range(1, plen - 1);
        for (int i = 0; i < cnt; i++) body.push_back(p[i]);
      end
    end
    while (body.size() > len) void'(body.pop_back());
    add_length(29'(len));
    foreach (body[i]) stream_q.push_back(body[i]);
  endtask

  task automatic send_byte(input byte_t b, input bit fixed, input beat_t fixed_beat);
    int unsigned gap;
    bit          emits;
    beat_t       beat;
    if (src_calm != 0) begin
      src_calm--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 80);
    end
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    n_bytes++;
    deframe_byte(b, emits, beat);
    if (fixed) want_q.push_back(fixed_beat);
    else if (emits) want_q.push_back(beat);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sink_stall
    int unsigned stall;
    if (!rst_ni) begin
      tx_if.ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      stall = (sink_calm != 0) ? 0 : idle_len();
      if (sink_calm != 0) sink_calm <= sink_calm - 1;
      else if ($urandom_range(0, 199) == 0) sink_calm <= $urandom_range(20, 100);
      if (stall == 0) begin
        tx_if.ready <= 1'b1;
      end else begin
        tx_if.ready <= 1'b0;
        sink_hold <= stall - 1;
      end
    end
  end

  always @(posedge clk_i) begin : beat_check
    beat_t w;
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      if (tx_if.out_kind == KIND_END) begin
        n_end++;
        reply_seen[tx_if.reply_type]++;
      end else begin
        n_payload++;
      end
      if (want_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, got kind %0h byte %0h reply %0h",
                 $time, tx_if.out_kind, tx_if.payload_byte, tx_if.reply_type);
      end else begin
        w = want_q.pop_front();
        check_field("out_kind", 8'(w.kind), 8'(tx_if.out_kind));
        check_field("payload_byte", w.data, tx_if.payload_byte);
        check_field("word_first", 8'(w.first), 8'(tx_if.word_first));
        check_field("word_last", 8'(w.last), 8'(tx_if.word_last));
        check_field("reply_type", 8'(w.reply), 8'(tx_if.reply_type));
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    pfx_left = '0;
    len_acc = '0;
    pay_left = '0;
    sent_reply = REPLY_NONE;
    open_word();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (FRAMING_CASES[i]) begin
      send_byte(FRAMING_CASES[i].rx, FRAMING_CASES[i].fixed, FRAMING_CASES[i].res);
    end

    // Mostly whole sentences; some words carry noise and some sentences
    // run on without the closing empty word.
    while (stream_q.size() < STREAM_BYTES) begin
      repeat ($urandom_range(0, 4)) add_word($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) != 0) add_length('0);
    end
    while (stream_q.size() != 0) send_byte(stream_q.pop_front(), 1'b0, NO_BEAT);

    // The longest length the prefix can carry; the word never completes.
    for (int i = 0; i < 4; i++) send_byte(8'hFF, 1'b0, NO_BEAT);
    repeat (TAIL_BYTES) send_byte(byte_t'($urandom_range(0, 255)), 1'b0, NO_BEAT);
    rx_if.valid <= 1'b0;

    while (want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d payload beats and %0d sentence ends.",
             n_bytes, n_payload, n_end);
    $display("Sentence replies: none %0d, done %0d, trap %0d, fatal %0d.",
             reply_seen[0], reply_seen[1], reply_seen[2], reply_seen[3]);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lpwd_pkg.sv
src/lpwd_if.sv
src/lpwd_scan.sv
src/length_prefixed_word_deframer_core.sv
tb/length_prefixed_word_deframer_core_tb.sv
